### rtl/mboh_pkg.sv
// shared types, constants and helpers for the masked bit occurrence histogram
package mboh_pkg;

  localparam int WORD_COUNT  = 128;
  localparam int COUNT_BITS  = 32;
  localparam int LANES       = 32;
  localparam int LANE_W      = 5;
  localparam int ROW_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int PIXEL_COUNT = WORD_COUNT * LANES;
  localparam int OUTQ_DEPTH  = 3;
  localparam int OUTQ_PTR_W  = 2;

  typedef enum logic [1:0] {
    REQ_MASK  = 2'd0,
    REQ_IMAGE = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    logic [11:0] pixel_echo;
    logic [31:0] pixel_count;
  } result_t;

  // 7-bit word or row field to a memory row index
  function automatic logic [ROW_W-1:0] row_of(input logic [6:0] idx);
    logic [ROW_W+6:0] ext;
    ext = {{ROW_W{1'b0}}, idx};
    return ext[ROW_W-1:0];
  endfunction

  // counter value clamped to the 32-bit result field
  function automatic logic [31:0] clamp32(input count_t c);
    logic [COUNT_BITS+31:0] ext;
    ext = {32'd0, c};
    if (ext[COUNT_BITS+31:32] != '0) begin
      return 32'hFFFF_FFFF;
    end
    return ext[31:0];
  endfunction

endpackage

### rtl/masked_bit_occurrence_histogram_unit.sv
// top level: masked per-pixel bit occurrence histogram with banked counter memories
// a read transfer's result passes the update stage registers and then the result queue, whose head drives m_tdata
// throughput: one request per cycle of any kind while s_tready is high, read-modify-write on 32 counter banks
// a repeated row is served by forwarding the last written row, so no interlock stalls
// s_tready drops only when the three-entry result queue could not take pending reads
// rst (synchronous) clears row and mask valid bits at once: no clearing pass is needed
module masked_bit_occurrence_histogram_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // word_index[6:0], data_word[38:7], pixel_select[50:39]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // pixel_echo[11:0], pixel_count[43:12]
);

  localparam int RW = mboh_pkg::ROW_W;

  // request fields
  mboh_pkg::req_t in_req;
  logic [6:0]     in_word;
  logic [31:0]    in_data;
  logic [11:0]    in_pixel;
  logic           s_accept;
  logic [RW-1:0]  in_row;
  logic           in_word_ok;
  logic           in_pixel_ok;
  logic           in_range;

  assign in_req   = mboh_pkg::req_t'(s_tuser);
  assign in_word  = s_tdata[6:0];
  assign in_data  = s_tdata[38:7];
  assign in_pixel = s_tdata[50:39];
  assign s_accept = s_tvalid & s_tready;

  assign in_word_ok  = (32'(in_word) < 32'(mboh_pkg::WORD_COUNT));
  assign in_pixel_ok = (32'(in_pixel) < 32'(mboh_pkg::PIXEL_COUNT));
  assign in_range    = (in_req == mboh_pkg::REQ_READ) ? in_pixel_ok : in_word_ok;
  // reads address the row holding the pixel, the other requests the word row
  assign in_row = (in_req == mboh_pkg::REQ_READ) ? mboh_pkg::row_of(in_pixel[11:5])
                                                 : mboh_pkg::row_of(in_word);

  // mask store: written at acceptance, valid bits stand for the all-zero reset
  logic [mboh_pkg::WORD_COUNT-1:0] mask_valid;
  logic [31:0] mask_q;
  logic        mask_we;

  assign mask_we = s_accept & (in_req == mboh_pkg::REQ_MASK) & in_word_ok;

  mboh_ram #(
    .DEPTH (mboh_pkg::WORD_COUNT),
    .WIDTH (32)
  ) u_mask_ram (
    .clk   (clk),
    .we    (mask_we),
    .waddr (in_row),
    .wdata (in_data),
    .raddr (in_row),
    .rdata (mask_q)
  );

  // update stage registers, loaded in the cycle after acceptance when the ram data arrive
  logic               b_valid;
  mboh_pkg::req_t     b_req;
  logic [RW-1:0]      b_row;
  logic               b_in_range;
  logic [mboh_pkg::LANE_W-1:0] b_lane;
  logic [11:0]        b_pixel;
  logic [31:0]        b_data;
  logic               b_mask_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid    <= 1'b0;
      mask_valid <= '0;
    end else begin
      b_valid <= s_accept;
      if (mask_we) begin
        mask_valid[in_row] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      b_req      <= in_req;
      b_row      <= in_row;
      b_in_range <= in_range;
      b_lane     <= in_pixel[4:0];
      b_pixel    <= in_pixel;
      b_data     <= in_data;
      b_mask_ok  <= mask_valid[in_row];
    end
  end

  logic b_img_wr;
  logic b_clear;
  logic b_read;

  assign b_img_wr = b_valid & (b_req == mboh_pkg::REQ_IMAGE) & b_in_range;
  assign b_clear  = b_valid & (b_req == mboh_pkg::REQ_CLEAR);
  assign b_read   = b_valid & (b_req == mboh_pkg::REQ_READ);

  // counter banks: bank i holds pixel 32*row+i, i.e. bit 31-i of the word
  mboh_pkg::count_t cnt_q    [mboh_pkg::LANES];
  mboh_pkg::count_t cnt_cur  [mboh_pkg::LANES];
  mboh_pkg::count_t cnt_next [mboh_pkg::LANES];

  for (genvar i = 0; i < mboh_pkg::LANES; i++) begin : g_bank
    mboh_ram #(
      .DEPTH (mboh_pkg::WORD_COUNT),
      .WIDTH (mboh_pkg::COUNT_BITS)
    ) u_cnt_ram (
      .clk   (clk),
      .we    (b_img_wr),
      .waddr (b_row),
      .wdata (cnt_next[i]),
      .raddr (in_row),
      .rdata (cnt_q[i])
    );
  end

  // row valid bits: a cleared or never written row reads as zero
  logic [mboh_pkg::WORD_COUNT-1:0] row_valid;

  // forwarding of the row written on the previous edge, which the ram read missed
  logic             fwd_valid;
  logic [RW-1:0]    fwd_row;
  mboh_pkg::count_t fwd_data [mboh_pkg::LANES];
  logic             fwd_hit;
  logic [31:0]      bits;

  assign fwd_hit = fwd_valid & (fwd_row == b_row);
  assign bits    = b_data ^ (b_mask_ok ? mask_q : 32'd0);

  always_comb begin
    for (int i = 0; i < mboh_pkg::LANES; i++) begin
      if (fwd_hit) begin
        cnt_cur[i] = fwd_data[i];
      end else if (row_valid[b_row]) begin
        cnt_cur[i] = cnt_q[i];
      end else begin
        cnt_cur[i] = '0;
      end
      // saturating increment of every lane whose masked bit is set
      if (bits[mboh_pkg::LANES-1-i] && (cnt_cur[i] != '1)) begin
        cnt_next[i] = cnt_cur[i] + 1'b1;
      end else begin
        cnt_next[i] = cnt_cur[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= b_img_wr;
      if (b_clear) begin
        row_valid <= '0;
      end else if (b_img_wr) begin
        row_valid[b_row] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_img_wr) begin
      fwd_row  <= b_row;
      fwd_data <= cnt_next;
    end
  end

  // read result into the output queue
  mboh_pkg::result_t q_data;
  logic [mboh_pkg::OUTQ_PTR_W-1:0] q_count;
  logic q_push;

  assign q_push             = b_read;
  assign q_data.pixel_echo  = b_pixel;
  assign q_data.pixel_count = b_in_range ? mboh_pkg::clamp32(cnt_cur[b_lane]) : 32'd0;

  mboh_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .count     (q_count),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // credit: queue entries plus a read still in the update stage
  assign s_tready = (({1'b0, q_count} + {{mboh_pkg::OUTQ_PTR_W{1'b0}}, b_read})
                     < (mboh_pkg::OUTQ_PTR_W + 1)'(mboh_pkg::OUTQ_DEPTH));

  // checks
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_count < mboh_pkg::OUTQ_PTR_W'(mboh_pkg::OUTQ_DEPTH)))
    else $error("result queue overflow");

  a_fwd_row_valid: assert property (@(posedge clk) disable iff (rst)
    fwd_valid |-> row_valid[fwd_row])
    else $error("forwarded row not marked valid");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    b_clear |=> (row_valid == '0))
    else $error("clear left a row valid");

  a_read_reaches_queue: assert property (@(posedge clk) disable iff (rst)
    (s_accept && (in_req == mboh_pkg::REQ_READ)) |=> q_push)
    else $error("read transfer produced no result");

endmodule

### rtl/mboh_ram.sv
// simple dual-port synchronous ram, registered read, read-before-write
module mboh_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/mboh_outq.sv
// small result queue that decouples the update pipe from the output stream
module mboh_outq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  mboh_pkg::result_t           push_data,
  output logic [mboh_pkg::OUTQ_PTR_W-1:0] count,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [47:0]                 m_tdata
);

  localparam logic [mboh_pkg::OUTQ_PTR_W-1:0] LAST =
    mboh_pkg::OUTQ_PTR_W'(mboh_pkg::OUTQ_DEPTH - 1);

  mboh_pkg::result_t entry [mboh_pkg::OUTQ_DEPTH];
  logic [mboh_pkg::OUTQ_PTR_W-1:0] wr_ptr;
  logic [mboh_pkg::OUTQ_PTR_W-1:0] rd_ptr;
  logic pop;

  assign pop      = m_tvalid & m_tready;
  assign m_tvalid = (count != '0);
  // pixel_echo in the low bits, pixel_count above it
  assign m_tdata  = {4'd0, entry[rd_ptr].pixel_count, entry[rd_ptr].pixel_echo};

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
